// ----- hdl/tccw_pkg.sv -----
// Shared types and constants for the text console cell writer.
package tccw_pkg;

  // Field widths of the command and result words.
  localparam int CMD_W  = 2;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int CELL_W = CHAR_W + ATTR_W;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_PUT       = 2'd0;
  localparam logic [CMD_W-1:0] CMD_BACKSPACE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR     = 2'd2;
  localparam logic [CMD_W-1:0] CMD_READ      = 2'd3;

  // Character codes with a special meaning.
  localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_ERROR   = 8'h45;
  localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_BLANK   = 8'h08;

  // Attribute used after reset and in place of a zero text attribute.
  localparam logic [ATTR_W-1:0] ATTR_DEFAULT     = 8'h0F;
  localparam logic [ATTR_W-1:0] ATTR_ERROR_RESET = 8'hF4;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_TEXT_ATTR  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ERROR_ATTR = 1'b1;

  // Controller states.
  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_SCROLL,
    ST_FILL,
    ST_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic exec;
    logic scroll_step;
    logic fill_step;
    logic fill_default;
    logic result_load;
  } dp_ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_clear;
    logic need_scroll;
    logic scroll_last;
    logic fill_last;
    logic out_busy;
  } dp_status_t;

endpackage

// ----- hdl/tccw_if.sv -----
// Command and result channel interfaces of the text console cell writer.
interface tccw_in_if;
  import tccw_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [CHAR_W-1:0] character;
  logic              at_cursor;
  logic [ROW_W-1:0]  row;
  logic [COL_W-1:0]  col;

  modport source (output valid, cmd, character, at_cursor, row, col, input ready);
  modport sink   (input valid, cmd, character, at_cursor, row, col, output ready);
endinterface

interface tccw_out_if;
  import tccw_pkg::*;

  logic              valid;
  logic              ready;
  logic [ROW_W-1:0]  cursor_row;
  logic [COL_W-1:0]  cursor_col;
  logic [CHAR_W-1:0] read_char;
  logic [ATTR_W-1:0] read_attr;
  logic              out_of_range;

  modport source (output valid, cursor_row, cursor_col, read_char, read_attr, out_of_range,
                  input ready);
  modport sink   (input valid, cursor_row, cursor_col, read_char, read_attr, out_of_range,
                  output ready);
endinterface

// ----- hdl/tccw_ctrl.sv -----
// Controller state machine that sequences commands, scrolls, fills and results.
module tccw_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  tccw_pkg::dp_status_t status,
  output tccw_pkg::dp_ctrl_t   ctrl
);
  import tccw_pkg::*;

  state_t state;
  state_t state_next;

  // State register; reset starts the clearing pass.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    ctrl       = '0;
    unique case (state)
      ST_INIT: begin
        ctrl.fill_step    = 1'b1;
        ctrl.fill_default = 1'b1;
        if (status.fill_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctrl.load  = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        ctrl.exec = 1'b1;
        if (status.is_clear) begin
          state_next = ST_FILL;
        end else if (status.need_scroll) begin
          state_next = ST_SCROLL;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_SCROLL: begin
        ctrl.scroll_step = 1'b1;
        if (status.scroll_last) begin
          state_next = ST_FILL;
        end
      end
      ST_FILL: begin
        ctrl.fill_step = 1'b1;
        if (status.fill_last) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!status.out_busy) begin
          ctrl.result_load = 1'b1;
          state_next       = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_INIT;
      end
    endcase
  end

endmodule

// ----- hdl/tccw_datapath.sv -----
// Datapath: screen memory, cursor, sweep pointer, settings and result register.
module tccw_datapath #(
  parameter int ROWS = 25,
  parameter int COLS = 80
) (
  input  logic                          clk,
  input  logic                          rst,
  input  tccw_pkg::dp_ctrl_t            ctrl,
  output tccw_pkg::dp_status_t          status,
  input  logic                          cfg_write,
  input  logic [tccw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tccw_pkg::ATTR_W-1:0]   cfg_data,
  input  logic [tccw_pkg::CMD_W-1:0]    in_cmd,
  input  logic [tccw_pkg::CHAR_W-1:0]   in_character,
  input  logic                          in_at_cursor,
  input  logic [tccw_pkg::ROW_W-1:0]    in_row,
  input  logic [tccw_pkg::COL_W-1:0]    in_col,
  tccw_out_if.source                    out_ch
);
  import tccw_pkg::*;

  localparam int CELLS  = ROWS * COLS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int PTR_W  = $clog2(CELLS + 1);

  localparam logic [ROW_W-1:0]  ROWS_R   = ROW_W'(ROWS);
  localparam logic [ROW_W-1:0]  ROW_LAST = ROW_W'(ROWS - 1);
  localparam logic [COL_W-1:0]  COLS_C   = COL_W'(COLS);
  localparam logic [COL_W-1:0]  COL_LAST = COL_W'(COLS - 1);
  localparam logic [ADDR_W-1:0] COLS_A   = ADDR_W'(COLS);
  localparam logic [ADDR_W-1:0] LAST_A   = ADDR_W'(CELLS - 1);
  localparam logic [PTR_W-1:0]  CELLS_P  = PTR_W'(CELLS);
  localparam logic [PTR_W-1:0]  COLS_P   = PTR_W'(COLS);
  localparam logic [PTR_W-1:0]  BOTTOM_P = PTR_W'(CELLS - COLS);
  localparam logic [PTR_W-1:0]  LAST_P   = PTR_W'(CELLS - 1);

  // Screen store, character in the low byte and attribute in the high byte.
  logic [CELL_W-1:0] mem [CELLS];
  logic [CELL_W-1:0] rd_data;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [CELL_W-1:0] mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;

  // Settings, captured command and cursor.
  logic [ATTR_W-1:0] text_attr;
  logic [ATTR_W-1:0] error_attr;
  logic [ATTR_W-1:0] attr;
  logic [CMD_W-1:0]  req_cmd;
  logic [CHAR_W-1:0] req_char;
  logic              req_at_cursor;
  logic [ROW_W-1:0]  req_row;
  logic [COL_W-1:0]  req_col;
  logic [ROW_W-1:0]  cur_row;
  logic [COL_W-1:0]  cur_col;
  logic [PTR_W-1:0]  ptr;

  // Command decode.
  logic              offscreen;
  logic              put_error;
  logic              oor;
  logic [ROW_W-1:0]  tgt_row;
  logic [COL_W-1:0]  tgt_col;
  logic [ROW_W-1:0]  nxt_row;
  logic [COL_W-1:0]  nxt_col;
  logic [ROW_W-1:0]  wr_row;
  logic [COL_W-1:0]  wr_col;
  logic [CHAR_W-1:0] wr_char;
  logic              ex_we;
  logic              cur_update;
  logic              need_scroll;
  logic [ADDR_W-1:0] req_addr;
  logic [ADDR_W-1:0] wr_addr;

  // Result register.
  logic              out_valid;
  logic [ROW_W-1:0]  res_row;
  logic [COL_W-1:0]  res_col;
  logic [CHAR_W-1:0] res_char;
  logic [ATTR_W-1:0] res_attr;
  logic              res_oor;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      text_attr  <= ATTR_DEFAULT;
      error_attr <= ATTR_ERROR_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_TEXT_ATTR:  text_attr  <= cfg_data;
        CFG_ERROR_ATTR: error_attr <= cfg_data;
        default: ;
      endcase
    end
  end

  assign attr = (text_attr == '0) ? ATTR_DEFAULT : text_attr;

  // Capture the accepted command word.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      req_cmd       <= in_cmd;
      req_char      <= in_character;
      req_at_cursor <= in_at_cursor;
      req_row       <= in_row;
      req_col       <= in_col;
    end
  end

  assign offscreen = (req_row >= ROWS_R) || (req_col >= COLS_C);
  assign put_error = (req_cmd == CMD_PUT) && !req_at_cursor && offscreen;
  assign oor       = ((req_cmd == CMD_PUT) && !req_at_cursor && offscreen) ||
                     ((req_cmd == CMD_READ) && offscreen);
  assign tgt_row   = req_at_cursor ? cur_row : req_row;
  assign tgt_col   = req_at_cursor ? cur_col : req_col;

  // Cell write and cursor move of a put or a backspace, and the cursor home of a clear.
  always_comb begin
    nxt_row    = cur_row;
    nxt_col    = cur_col;
    wr_row     = tgt_row;
    wr_col     = tgt_col;
    wr_char    = CHAR_SPACE;
    ex_we      = 1'b0;
    cur_update = 1'b0;
    case (req_cmd)
      CMD_PUT: begin
        if (!put_error) begin
          cur_update = 1'b1;
          if (req_char == CHAR_NEWLINE) begin
            nxt_row = tgt_row + ROW_W'(1);
            nxt_col = '0;
          end else if (req_char == CHAR_BLANK) begin
            ex_we   = 1'b1;
            nxt_row = tgt_row;
            nxt_col = tgt_col;
          end else begin
            ex_we   = 1'b1;
            wr_char = req_char;
            if (tgt_col == COL_LAST) begin
              nxt_row = tgt_row + ROW_W'(1);
              nxt_col = '0;
            end else begin
              nxt_row = tgt_row;
              nxt_col = tgt_col + COL_W'(1);
            end
          end
        end
      end
      CMD_BACKSPACE: begin
        ex_we      = 1'b1;
        cur_update = 1'b1;
        if (cur_col != '0) begin
          nxt_row = cur_row;
          nxt_col = cur_col - COL_W'(1);
        end else if (cur_row != '0) begin
          nxt_row = cur_row - ROW_W'(1);
          nxt_col = COL_LAST;
        end else begin
          nxt_row = '0;
          nxt_col = '0;
        end
        wr_row = nxt_row;
        wr_col = nxt_col;
      end
      CMD_CLEAR: begin
        cur_update = 1'b1;
        nxt_row    = '0;
        nxt_col    = '0;
      end
      default: ;
    endcase
  end

  assign need_scroll = cur_update && (nxt_row == ROWS_R);
  assign wr_addr  = ADDR_W'(wr_row) * COLS_A + ADDR_W'(wr_col);
  assign req_addr = offscreen ? '0 : (ADDR_W'(req_row) * COLS_A + ADDR_W'(req_col));

  // Cursor register.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_row <= '0;
      cur_col <= '0;
    end else if (ctrl.exec && cur_update) begin
      cur_row <= need_scroll ? ROW_LAST : nxt_row;
      cur_col <= nxt_col;
    end
  end

  // Sweep pointer for the scroll copy and the fills.
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr <= '0;
    end else if (ctrl.exec) begin
      if (req_cmd == CMD_CLEAR) begin
        ptr <= '0;
      end else if (need_scroll) begin
        ptr <= COLS_P;
      end
    end else if (ctrl.scroll_step) begin
      ptr <= (ptr == CELLS_P) ? BOTTOM_P : ptr + PTR_W'(1);
    end else if (ctrl.fill_step) begin
      ptr <= ptr + PTR_W'(1);
    end
  end

  // Memory write port: fills, scroll copies and single cell writes.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = wr_addr;
    mem_wdata = {attr, wr_char};
    if (ctrl.fill_step) begin
      mem_we    = 1'b1;
      mem_waddr = ptr[ADDR_W-1:0];
      mem_wdata = {(ctrl.fill_default ? ATTR_DEFAULT : attr), CHAR_SPACE};
    end else if (ctrl.scroll_step) begin
      mem_we    = ptr > COLS_P;
      mem_waddr = ADDR_W'(ptr - COLS_P - PTR_W'(1));
      mem_wdata = rd_data;
    end else if (ctrl.exec) begin
      if (put_error) begin
        mem_we    = 1'b1;
        mem_waddr = LAST_A;
        mem_wdata = {error_attr, CHAR_ERROR};
      end else begin
        mem_we = ex_we;
      end
    end
  end

  // The scroll reads one row ahead of where it writes.
  assign mem_raddr = ctrl.scroll_step ? ((ptr < CELLS_P) ? ptr[ADDR_W-1:0] : '0) : req_addr;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[mem_raddr];
  end

  // Result register holds a finished word until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.result_load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.result_load) begin
      res_row <= cur_row;
      res_col <= cur_col;
      res_oor <= oor;
      if ((req_cmd == CMD_READ) && !offscreen) begin
        res_char <= rd_data[CHAR_W-1:0];
        res_attr <= rd_data[CELL_W-1:CHAR_W];
      end else begin
        res_char <= '0;
        res_attr <= '0;
      end
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.cursor_row   = res_row;
  assign out_ch.cursor_col   = res_col;
  assign out_ch.read_char    = res_char;
  assign out_ch.read_attr    = res_attr;
  assign out_ch.out_of_range = res_oor;

  // Status back to the controller.
  assign status.is_clear    = (req_cmd == CMD_CLEAR);
  assign status.need_scroll = need_scroll;
  assign status.scroll_last = (ptr == CELLS_P);
  assign status.fill_last   = (ptr == LAST_P);
  assign status.out_busy    = out_valid && !out_ch.ready;

endmodule

// ----- hdl/text_console_cell_writer.sv -----
// Put, backspace and read: after the command is taken, EXEC runs it and DONE loads the result word
// once the sink has taken the last one. A put that scrolls adds one pointer sweep that copies cells
// a row up, then the bottom row is blanked. Clear adds a fill of the whole screen with spaces.
// One command is in work at a time; the result register frees the next command from the sink.
// Reset (rst, synchronous) sets the cursor home and the settings to their defaults, then a
// clearing pass writes spaces before the first command is taken.
module text_console_cell_writer #(
  parameter int ROWS = 25,
  parameter int COLS = 80
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [tccw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tccw_pkg::ATTR_W-1:0]   cfg_data,
  tccw_in_if.sink                       in_ch,
  tccw_out_if.source                    out_ch
);
  import tccw_pkg::*;

  dp_ctrl_t   ctrl;
  dp_status_t status;
  logic       in_ready;

  assign in_ch.ready = in_ready;

  // Command sequencing.
  tccw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .status   (status),
    .ctrl     (ctrl)
  );

  // Screen store and cursor.
  tccw_datapath #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .status       (status),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_cmd       (in_ch.cmd),
    .in_character (in_ch.character),
    .in_at_cursor (in_ch.at_cursor),
    .in_row       (in_ch.row),
    .in_col       (in_ch.col),
    .out_ch       (out_ch)
  );

endmodule

// ----- tb/tb_text_console_cell_writer.sv -----
// Self-checking testbench for the text console cell writer: directed table, then random phases.
`timescale 1ns / 100ps

module tb_text_console_cell_writer;
  import tccw_pkg::*;

  localparam int SCREEN_ROWS  = 25;
  localparam int SCREEN_COLS  = 80;
  localparam int SCREEN_SIZE  = SCREEN_ROWS * SCREEN_COLS;
  localparam int DIRECTED_N   = 25;
  localparam int PHASE_ITEMS  = 80;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [CHAR_W-1:0] character;
    logic              at_cursor;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
  } console_cmd_t;

  typedef struct packed {
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_col;
    logic [CHAR_W-1:0] read_char;
    logic [ATTR_W-1:0] read_attr;
    logic              out_of_range;
  } console_result_t;

  typedef struct packed {
    console_cmd_t    command;
    logic            typed;
    console_result_t result;
  } directed_row_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [ATTR_W-1:0]    cfg_data;

  tccw_in_if  cmd_if ();
  tccw_out_if res_if ();

  // Predictor state: screen image, cursor and the attribute settings.
  logic [CELL_W-1:0] screen_image [SCREEN_SIZE];
  int unsigned       cursor_cell;
  logic [ATTR_W-1:0] text_attr_reg;
  logic [ATTR_W-1:0] error_attr_reg;

  console_result_t pending_results [$];
  int              mismatches;
  int              send_idle_pct;
  int              recv_stall_pct;
  int              hold_requests;
  int              hold_served;
  int              hold_left;

  // Directed rows; rows with typed set carry an expectation read straight off the spec.
  directed_row_t directed_rows [DIRECTED_N] = '{
    '{'{CMD_READ, 8'h00, 1'b0, 5'd0, 7'd0}, 1'b1, '{5'd0, 7'd0, CHAR_SPACE, ATTR_DEFAULT, 1'b0}},
    '{'{CMD_READ, 8'h00, 1'b0, 5'd24, 7'd79}, 1'b1,
      '{5'd0, 7'd0, CHAR_SPACE, ATTR_DEFAULT, 1'b0}},
    '{'{CMD_READ, 8'hFF, 1'b1, 5'd31, 7'd127}, 1'b1, '{5'd0, 7'd0, 8'h00, 8'h00, 1'b1}},
    '{'{CMD_READ, 8'h00, 1'b0, 5'd25, 7'd0}, 1'b1, '{5'd0, 7'd0, 8'h00, 8'h00, 1'b1}},
    '{'{CMD_READ, 8'h00, 1'b0, 5'd0, 7'd80}, 1'b1, '{5'd0, 7'd0, 8'h00, 8'h00, 1'b1}},
    '{'{CMD_PUT, 8'h41, 1'b0, 5'd31, 7'd127}, 1'b1, '{5'd0, 7'd0, 8'h00, 8'h00, 1'b1}},
    '{'{CMD_READ, 8'h00, 1'b0, 5'd24, 7'd79}, 1'b1,
      '{5'd0, 7'd0, CHAR_ERROR, ATTR_ERROR_RESET, 1'b0}},
    '{'{CMD_PUT, 8'h48, 1'b1, 5'd0, 7'd0}, 1'b1, '{5'd0, 7'd1, 8'h00, 8'h00, 1'b0}},
    '{'{CMD_PUT, 8'hFF, 1'b1, 5'd0, 7'd0}, 1'b1, '{5'd0, 7'd2, 8'h00, 8'h00, 1'b0}},
    '{'{CMD_PUT, 8'h00, 1'b1, 5'd0, 7'd0}, 1'b1, '{5'd0, 7'd3, 8'h00, 8'h00, 1'b0}},
    '{'{CMD_PUT, CHAR_NEWLINE, 1'b1, 5'd0, 7'd0}, 1'b1, '{5'd1, 7'd0, 8'h00, 8'h00, 1'b0}},
    '{'{CMD_PUT, CHAR_BLANK, 1'b1, 5'd0, 7'd0}, 1'b1, '{5'd1, 7'd0, 8'h00, 8'h00, 1'b0}},
    '{'{CMD_BACKSPACE, 8'h00, 1'b0, 5'd0, 7'd0}, 1'b1, '{5'd0, 7'd79, 8'h00, 8'h00, 1'b0}},
    '{'{CMD_READ, 8'h00, 1'b0, 5'd0, 7'd1}, 1'b1, '{5'd0, 7'd79, 8'hFF, ATTR_DEFAULT, 1'b0}},
    '{'{CMD_PUT, 8'h5A, 1'b0, 5'd24, 7'd79}, 1'b1, '{5'd24, 7'd0, 8'h00, 8'h00, 1'b0}},
    '{'{CMD_READ, 8'h00, 1'b0, 5'd23, 7'd79}, 1'b1, '{5'd24, 7'd0, 8'h5A, ATTR_DEFAULT, 1'b0}},
    '{'{CMD_PUT, CHAR_NEWLINE, 1'b0, 5'd24, 7'd0}, 1'b1, '{5'd24, 7'd0, 8'h00, 8'h00, 1'b0}},
    '{'{CMD_PUT, 8'h61, 1'b0, 5'd0, 7'd0}, 1'b0, '0},
    '{'{CMD_BACKSPACE, 8'hFF, 1'b1, 5'd31, 7'd127}, 1'b0, '0},
    '{'{CMD_BACKSPACE, 8'h00, 1'b0, 5'd0, 7'd0}, 1'b1, '{5'd0, 7'd0, 8'h00, 8'h00, 1'b0}},
    '{'{CMD_READ, 8'h00, 1'b0, 5'd0, 7'd0}, 1'b1, '{5'd0, 7'd0, CHAR_SPACE, ATTR_DEFAULT, 1'b0}},
    '{'{CMD_CLEAR, 8'hFF, 1'b1, 5'd31, 7'd127}, 1'b1, '{5'd0, 7'd0, 8'h00, 8'h00, 1'b0}},
    '{'{CMD_READ, 8'h00, 1'b0, 5'd24, 7'd79}, 1'b1,
      '{5'd0, 7'd0, CHAR_SPACE, ATTR_DEFAULT, 1'b0}},
    '{'{CMD_PUT, 8'h71, 1'b1, 5'd31, 7'd127}, 1'b1, '{5'd0, 7'd1, 8'h00, 8'h00, 1'b0}},
    '{'{CMD_READ, 8'hFF, 1'b1, 5'd0, 7'd0}, 1'b1, '{5'd0, 7'd1, 8'h71, ATTR_DEFAULT, 1'b0}}
  };

  text_console_cell_writer #(
    .ROWS (SCREEN_ROWS),
    .COLS (SCREEN_COLS)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (cmd_if),
    .out_ch    (res_if)
  );

  // Clock generation.
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Apply one command to the screen image and return the word it should produce.
  function automatic console_result_t apply_command(console_cmd_t c);
    console_result_t   r;
    logic [ATTR_W-1:0] attr;
    int unsigned       pos;
    int unsigned       idx;
    bit                off_screen;
    r          = '0;
    attr       = (text_attr_reg == '0) ? ATTR_DEFAULT : text_attr_reg;
    off_screen = (c.row >= SCREEN_ROWS) || (c.col >= SCREEN_COLS);
    case (c.cmd)
      CMD_PUT: begin
        if (!c.at_cursor && off_screen) begin
          screen_image[SCREEN_SIZE-1] = {error_attr_reg, CHAR_ERROR};
          r.out_of_range = 1'b1;
        end else begin
          pos = c.at_cursor ? cursor_cell : c.row * SCREEN_COLS + c.col;
          if (c.character == CHAR_NEWLINE) begin
            pos = (pos / SCREEN_COLS + 1) * SCREEN_COLS;
          end else if (c.character == CHAR_BLANK) begin
            screen_image[pos] = {attr, CHAR_SPACE};
          end else begin
            screen_image[pos] = {attr, c.character};
            pos++;
          end
          // Running off the bottom moves every row up and blanks the last one.
          if (pos >= SCREEN_SIZE) begin
            for (idx = 0; idx < SCREEN_SIZE - SCREEN_COLS; idx++) begin
              screen_image[idx] = screen_image[idx + SCREEN_COLS];
            end
            for (idx = SCREEN_SIZE - SCREEN_COLS; idx < SCREEN_SIZE; idx++) begin
              screen_image[idx] = {attr, CHAR_SPACE};
            end
            pos -= SCREEN_COLS;
          end
          cursor_cell = pos;
        end
      end
      CMD_BACKSPACE: begin
        pos = (cursor_cell > 0) ? cursor_cell - 1 : 0;
        screen_image[pos] = {attr, CHAR_SPACE};
        cursor_cell = pos;
      end
      CMD_CLEAR: begin
        for (idx = 0; idx < SCREEN_SIZE; idx++) begin
          screen_image[idx] = {attr, CHAR_SPACE};
        end
        cursor_cell = 0;
      end
      default: begin
        if (off_screen) begin
          r.out_of_range = 1'b1;
        end else begin
          {r.read_attr, r.read_char} = screen_image[c.row * SCREEN_COLS + c.col];
        end
      end
    endcase
    r.cursor_row = ROW_W'(cursor_cell / SCREEN_COLS);
    r.cursor_col = COL_W'(cursor_cell % SCREEN_COLS);
    return r;
  endfunction

  // Offer one command word, wait for it to be taken, then queue what it should return.
  task automatic send_command(console_cmd_t c, logic typed, console_result_t typed_result);
    console_result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_if.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_if.valid     <= 1'b1;
    cmd_if.cmd       <= c.cmd;
    cmd_if.character <= c.character;
    cmd_if.at_cursor <= c.at_cursor;
    cmd_if.row       <= c.row;
    cmd_if.col       <= c.col;
    do @(posedge clk); while (!cmd_if.ready);
    predicted = apply_command(c);
    pending_results.push_back(typed ? typed_result : predicted);
  endtask

  // Set both attributes, then run a burst of random commands and let the results drain.
  task automatic run_phase(logic [ATTR_W-1:0] text_attr, logic [ATTR_W-1:0] err_attr,
                           int idle_pct, int stall_pct, bit hold_off);
    console_cmd_t c;
    int unsigned  pick;
    int unsigned  kind;
    cfg_write      <= 1'b1;
    cfg_index      <= CFG_TEXT_ATTR;
    cfg_data       <= text_attr;
    @(posedge clk);
    cfg_index      <= CFG_ERROR_ATTR;
    cfg_data       <= err_attr;
    @(posedge clk);
    cfg_write      <= 1'b0;
    text_attr_reg  = text_attr;
    error_attr_reg = err_attr;
    send_idle_pct  = idle_pct;
    recv_stall_pct <= stall_pct;
    if (hold_off) begin
      hold_requests <= hold_requests + 1;
    end

    repeat (PHASE_ITEMS) begin
      c.character = CHAR_W'($urandom_range(255));
      c.at_cursor = 1'($urandom_range(1));
      c.row       = ROW_W'($urandom_range(31));
      c.col       = COL_W'($urandom_range(127));
      pick        = $urandom_range(99);
      if (pick < 45) begin
        // Typing at the cursor, with newlines often enough to reach the bottom row.
        c.cmd       = CMD_PUT;
        c.at_cursor = 1'b1;
        kind        = $urandom_range(99);
        if (kind < 12) begin
          c.character = CHAR_NEWLINE;
        end else if (kind < 16) begin
          c.character = CHAR_BLANK;
        end else if (kind < 90) begin
          c.character = CHAR_W'($urandom_range(126, 32));
        end
      end else if (pick < 62) begin
        // Positional put, biased to the bottom row; a tenth keep the random row and column, which can land off screen.
        c.cmd       = CMD_PUT;
        c.at_cursor = 1'b0;
        if ($urandom_range(9) != 0) begin
          c.row = ROW_W'(($urandom_range(2) == 0) ? SCREEN_ROWS - 1
                                                  : $urandom_range(SCREEN_ROWS - 1));
          c.col = COL_W'($urandom_range(SCREEN_COLS - 1));
        end
        if ($urandom_range(9) == 0) begin
          c.character = CHAR_NEWLINE;
        end
      end else if (pick < 85) begin
        // Reads; nine tenths get an on-screen address, half of those on the cursor row where recent writes sit.
        c.cmd = CMD_READ;
        if ($urandom_range(9) != 0) begin
          c.row = ROW_W'(($urandom_range(1) == 0) ? cursor_cell / SCREEN_COLS
                                                  : $urandom_range(SCREEN_ROWS - 1));
          c.col = COL_W'($urandom_range(SCREEN_COLS - 1));
        end
      end else if (pick < 98) begin
        c.cmd = CMD_BACKSPACE;
      end else begin
        c.cmd = CMD_CLEAR;
      end
      send_command(c, 1'b0, '0);
    end
    cmd_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Result side: random or held-off ready, and a field-by-field compare of every word taken.
  initial begin
    console_result_t want;
    res_if.ready = 1'b0;
    hold_served  = 0;
    hold_left    = 0;
    forever begin
      @(posedge clk);
      if (res_if.valid && res_if.ready) begin
        if (pending_results.size() == 0) begin
          $error("result word arrived with no command outstanding");
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (res_if.cursor_row !== want.cursor_row) begin
            $error("cursor_row: expected %0d, got %0d", want.cursor_row, res_if.cursor_row);
            mismatches++;
          end
          if (res_if.cursor_col !== want.cursor_col) begin
            $error("cursor_col: expected %0d, got %0d", want.cursor_col, res_if.cursor_col);
            mismatches++;
          end
          if (res_if.read_char !== want.read_char) begin
            $error("read_char: expected %h, got %h", want.read_char, res_if.read_char);
            mismatches++;
          end
          if (res_if.read_attr !== want.read_attr) begin
            $error("read_attr: expected %h, got %h", want.read_attr, res_if.read_attr);
            mismatches++;
          end
          if (res_if.out_of_range !== want.out_of_range) begin
            $error("out_of_range: expected %0d, got %0d", want.out_of_range, res_if.out_of_range);
            mismatches++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else if (hold_requests != hold_served) begin
        hold_served++;
        hold_left    = HOLD_CYCLES;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Main sequence.
  initial begin
    int unsigned idx;
    rst              = 1'b1;
    cfg_write        = 1'b0;
    cfg_index        = CFG_TEXT_ATTR;
    cfg_data         = '0;
    cmd_if.valid     = 1'b0;
    cmd_if.cmd       = CMD_PUT;
    cmd_if.character = '0;
    cmd_if.at_cursor = 1'b0;
    cmd_if.row       = '0;
    cmd_if.col       = '0;
    mismatches       = 0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    hold_requests    = 0;
    for (idx = 0; idx < SCREEN_SIZE; idx++) begin
      screen_image[idx] = {ATTR_DEFAULT, CHAR_SPACE};
    end
    cursor_cell    = 0;
    text_attr_reg  = ATTR_DEFAULT;
    error_attr_reg = ATTR_ERROR_RESET;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed part runs with the reset settings; the clearing pass just holds off ready.
    for (idx = 0; idx < DIRECTED_N; idx++) begin
      send_command(directed_rows[idx].command, directed_rows[idx].typed,
                   directed_rows[idx].result);
    end
    cmd_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);

    // Random phases across attribute extremes and idling patterns.
    run_phase(8'h00, 8'h00, 0, 0, 1'b0);
    run_phase(8'hFF, 8'hFF, 58, 0, 1'b0);
    run_phase(8'h01, 8'h80, 0, 58, 1'b0);
    run_phase(ATTR_W'($urandom_range(255)), ATTR_W'($urandom_range(255)), 35, 35, 1'b0);
    run_phase(ATTR_W'($urandom_range(255)), 8'h7F, 0, 0, 1'b1);
    run_phase(ATTR_W'($urandom_range(1, 254)), ATTR_W'($urandom_range(255)), 35, 35, 1'b0);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run (every command scrolling or clearing).
  initial begin
    #60_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/tccw_pkg.sv
hdl/tccw_if.sv
hdl/tccw_ctrl.sv
hdl/tccw_datapath.sv
hdl/text_console_cell_writer.sv
tb/tb_text_console_cell_writer.sv
